>>> hdl/normalized_conv3x3_stream_macros.svh
// Assertion macros used by the normalized 3x3 convolution stream top level.
`ifndef NORMALIZED_CONV3X3_STREAM_MACROS_SVH
`define NORMALIZED_CONV3X3_STREAM_MACROS_SVH
`ifndef SYNTH
`define NCV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define NCV_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `NCV_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define NCV_ASSERT(lbl, clk, rstn, prop, msg)
`define NCV_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> hdl/ncv_pkg.sv
// Types and constants shared by the normalized 3x3 convolution stream.
`timescale 1ns / 1ps
package ncv_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned FCOLS_W   = 11;
    localparam int unsigned FROWS_W   = 12;
    localparam int unsigned KROW_W    = 24;
    localparam int unsigned ROW_W     = 12;
    localparam int unsigned COL_W     = 10;
    localparam int unsigned VAL_W     = 13;
    localparam int unsigned CNT_ROW_W = 13;
    localparam int unsigned ACC_W     = 20;
    localparam int unsigned KSUM_W    = 11;
    localparam int unsigned QUO_W     = 12;
    localparam int unsigned TAPS      = 9;
    localparam int unsigned TDATA_W   = 40;
    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned PDATA_W   = 32;

    typedef enum logic [2:0] {
        REG_FRAME_COLS    = 3'd0,
        REG_FRAME_ROWS    = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MIDDLE = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4
    } t_reg_idx;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Window taps, index row * 3 + column, top-left first.
    typedef logic [TAPS-1:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic                    done;
        logic                    zero_kernel;
        logic signed [VAL_W-1:0] value;
    } t_flt_sts;

endpackage

>>> hdl/ncv_linemem.sv
// Line store memory: one word per column holding the two previous rows.
`timescale 1ns / 1ps
module ncv_linemem #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic [2*ncv_pkg::PIX_W-1:0]  i_wr_data,
    output logic [2*ncv_pkg::PIX_W-1:0]  o_rd_data
);
    import ncv_pkg::*;

    logic [2*PIX_W-1:0] r_mem [DEPTH];
    logic [2*PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/ncv_filter.sv
// Kernel unit: serial multiply-accumulate over the window and restoring divide.
`timescale 1ns / 1ps
module ncv_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  ncv_pkg::t_window            i_window,
    input  logic [ncv_pkg::KROW_W-1:0]  i_kernel_top,
    input  logic [ncv_pkg::KROW_W-1:0]  i_kernel_middle,
    input  logic [ncv_pkg::KROW_W-1:0]  i_kernel_bottom,
    output ncv_pkg::t_flt_sts           o_sts
);
    import ncv_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MAC  = 5'b00010,
        F_PREP = 5'b00100,
        F_DIV  = 5'b01000,
        F_DONE = 5'b10000
    } t_fstate;

    t_fstate                    r_state;
    logic [3:0]                 r_idx;
    logic [3:0]                 r_cnt;
    logic signed [ACC_W-1:0]    r_acc;
    logic [KSUM_W-1:0]          r_ksum;
    logic [KSUM_W-1:0]          r_rem;
    logic [QUO_W-1:0]           r_dlo;
    logic [QUO_W-1:0]           r_quo;
    logic                       r_neg;
    logic                       r_zero;

    logic [KROW_W-1:0]          w_rows [3];
    logic signed [PIX_W-1:0]    w_coef [TAPS];
    logic [KSUM_W-1:0]          w_ksum;
    logic signed [PIX_W:0]      w_cext;
    logic signed [2*PIX_W:0]    w_prod;
    logic [ACC_W-1:0]           w_mag;
    logic [ACC_W+2:0]           w_dividend;
    logic [QUO_W-1:0]           w_trial;
    logic [QUO_W-1:0]           w_diff;
    logic                       w_ge;
    logic [VAL_W-1:0]           w_quo_ext;

    assign w_rows[0] = i_kernel_top;
    assign w_rows[1] = i_kernel_middle;
    assign w_rows[2] = i_kernel_bottom;

    // Coefficients and the sum of their magnitudes; -128 gives 128.
    always_comb begin
        w_ksum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_coef[i*3+j] = signed'(w_rows[i][8*j +: 8]);
            end
        end
        for (int t = 0; t < TAPS; t++) begin
            w_cext = {w_coef[t][PIX_W-1], w_coef[t]};
            if (w_cext < 0) begin
                w_ksum = w_ksum + KSUM_W'(-w_cext);
            end else begin
                w_ksum = w_ksum + KSUM_W'(w_cext);
            end
        end
    end

    assign w_prod = $signed({1'b0, i_window[r_idx]}) * w_coef[r_idx];

    // The magnitude stays below 2^19, so its top bit is always zero.
    assign w_mag      = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_dividend = {w_mag[ACC_W-2:0], 4'b0000};
    assign w_trial    = {r_rem, r_dlo[QUO_W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_ksum});
    assign w_diff     = w_trial - {1'b0, r_ksum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_acc  <= '0;
                        r_idx  <= '0;
                        r_ksum <= w_ksum;
                        r_zero <= (w_ksum == '0);
                        r_neg  <= 1'b0;
                        r_quo  <= '0;
                        r_state <= (w_ksum == '0) ? F_DONE : F_MAC;
                    end
                end
                F_MAC: begin
                    r_acc <= r_acc + ACC_W'(w_prod);
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == 4'(TAPS - 1)) begin
                        r_state <= F_PREP;
                    end
                end
                F_PREP: begin
                    // Dividend is |acc| * 16; the quotient stays below 4096.
                    r_neg   <= r_acc[ACC_W-1];
                    r_rem   <= w_dividend[ACC_W+2 -: KSUM_W];
                    r_dlo   <= w_dividend[QUO_W-1:0];
                    r_cnt   <= '0;
                    r_state <= F_DIV;
                end
                F_DIV: begin
                    r_rem <= w_ge ? w_diff[KSUM_W-1:0] : w_trial[KSUM_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], w_ge};
                    r_dlo <= {r_dlo[QUO_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(QUO_W - 1)) begin
                        r_state <= F_DONE;
                    end
                end
                F_DONE: begin
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    assign w_quo_ext         = {1'b0, r_quo};
    assign o_sts.done        = (r_state == F_DONE);
    assign o_sts.zero_kernel = r_zero;
    assign o_sts.value       = r_neg ? signed'(-w_quo_ext) : signed'(w_quo_ext);

endmodule

>>> hdl/normalized_conv3x3_stream.sv
// Top level of the normalized 3x3 convolution stream with its register port.
`timescale 1ns / 1ps
`include "normalized_conv3x3_stream_macros.svh"
// An item with no result passes through the idle and read states; a border result then goes
// to the output state, and an interior result first waits in the calc state for the kernel
// unit's serial multiply-accumulate and divide.
// The line store is read when an item is accepted and written back in the read state, one item at a time.
// Reset (synchronous, active low) clears counters, window, output and registers to defaults;
// the line store is not cleared, its unwritten entries never reach a result.
module normalized_conv3x3_stream #(
    parameter int unsigned MAX_COLS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input stream.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] pixel
    input  logic                         s_axis_tuser,  // [0] req_type
    // Output stream.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [11:0] out_row, [21:12] out_col, [34:22] value, [39:35] zero fill
    output logic [ncv_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tuser,  // [0] zero_kernel
    output logic                         m_axis_tlast,  // frame_end
    // Register port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ncv_pkg::PADDR_W-1:0]  paddr,
    input  logic [ncv_pkg::PDATA_W-1:0]  pwdata,
    output logic [ncv_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import ncv_pkg::*;

    localparam int unsigned AW = $clog2(MAX_COLS);
    localparam int unsigned CW = $clog2(MAX_COLS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CALC = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // Configuration registers.
    logic [FCOLS_W-1:0]     r_frame_cols;
    logic [FROWS_W-1:0]     r_frame_rows;
    logic [KROW_W-1:0]      r_kernel_top;
    logic [KROW_W-1:0]      r_kernel_middle;
    logic [KROW_W-1:0]      r_kernel_bottom;

    // Frame state.
    t_state                 r_state;
    t_window                r_window;
    logic [PIX_W-1:0]       r_pix;
    logic [CNT_ROW_W-1:0]   r_in_row;
    logic [AW-1:0]          r_in_col;
    logic [CNT_ROW_W-1:0]   r_emit_row;
    logic [AW-1:0]          r_emit_col;

    // Result waiting for the output register.
    logic [ROW_W-1:0]       r_res_row;
    logic [COL_W-1:0]       r_res_col;
    logic [VAL_W-1:0]       r_res_value;
    logic                   r_res_zero;
    logic                   r_res_last;

    // Output register.
    logic                   r_out_valid;
    logic [TDATA_W-1:0]     r_out_tdata;
    logic                   r_out_tuser;
    logic                   r_out_tlast;

    logic [CW-1:0]          w_cols;
    logic [FROWS_W-1:0]     w_rows;
    logic                   w_drain;
    logic                   w_in_accept;
    logic                   w_take;
    logic                   w_cfg_write;
    t_reg_idx               w_reg_idx;
    logic [2*PIX_W-1:0]     w_rd_data;
    logic [PIX_W-1:0]       w_top;
    logic [PIX_W-1:0]       w_mid;
    logic                   w_mem_rd;
    logic                   w_mem_wr;
    logic                   w_emit;
    logic                   w_col_wrap;
    logic                   w_ec_wrap;
    logic                   w_interior;
    logic                   w_last;
    logic                   w_out_load;
    logic                   w_flt_start;
    logic [31:0]            w_ec32;
    t_flt_sts               w_sts;

    // Out-of-range sizes are clamped: zero columns or rows act as one,
    // columns beyond the line store act as its width.
    always_comb begin
        if (r_frame_cols == '0) begin
            w_cols = CW'(1);
        end else if (32'(r_frame_cols) > MAX_COLS) begin
            w_cols = CW'(MAX_COLS);
        end else begin
            w_cols = CW'(r_frame_cols);
        end
    end
    assign w_rows = (r_frame_rows == '0) ? FROWS_W'(1) : r_frame_rows;

    // Register port: writes are taken at once, reads return the stored value.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_reg_idx   = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_comb begin
        case (w_reg_idx)
            REG_FRAME_COLS:    prdata = PDATA_W'(r_frame_cols);
            REG_FRAME_ROWS:    prdata = PDATA_W'(r_frame_rows);
            REG_KERNEL_TOP:    prdata = PDATA_W'(r_kernel_top);
            REG_KERNEL_MIDDLE: prdata = PDATA_W'(r_kernel_middle);
            REG_KERNEL_BOTTOM: prdata = PDATA_W'(r_kernel_bottom);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols    <= FCOLS_W'(1024);
            r_frame_rows    <= FROWS_W'(1024);
            r_kernel_top    <= KROW_W'(65791);
            r_kernel_middle <= KROW_W'(131326);
            r_kernel_bottom <= KROW_W'(65791);
        end else if (w_cfg_write) begin
            case (w_reg_idx)
                REG_FRAME_COLS:    r_frame_cols    <= pwdata[FCOLS_W-1:0];
                REG_FRAME_ROWS:    r_frame_rows    <= pwdata[FROWS_W-1:0];
                REG_KERNEL_TOP:    r_kernel_top    <= pwdata[KROW_W-1:0];
                REG_KERNEL_MIDDLE: r_kernel_middle <= pwdata[KROW_W-1:0];
                REG_KERNEL_BOTTOM: r_kernel_bottom <= pwdata[KROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Once every input row has arrived, further transactions only drain the
    // pending outputs; a flush before that is dropped without effect.
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_drain       = (r_in_row >= CNT_ROW_W'(w_rows));
    assign w_in_accept   = s_axis_tvalid && s_axis_tready
                           && !((s_axis_tuser == REQ_FLUSH) && !w_drain);
    assign w_mem_rd      = w_in_accept;
    assign w_mem_wr      = (r_state == S_READ);

    assign w_top = w_rd_data[2*PIX_W-1:PIX_W];
    assign w_mid = w_rd_data[PIX_W-1:0];

    // The output for a position appears once the pixel one row and one
    // column later has arrived, so nothing is emitted for the first
    // cols + 1 pixels of a frame.
    always_comb begin
        if (r_in_row == '0) begin
            w_emit = !(CW'(r_in_col) <= w_cols);
        end else if (r_in_row == CNT_ROW_W'(1)) begin
            w_emit = (r_in_col != '0);
        end else begin
            w_emit = 1'b1;
        end
    end

    assign w_col_wrap = (CW'(r_in_col) + CW'(1) >= w_cols);
    assign w_ec_wrap  = (CW'(r_emit_col) + CW'(1) >= w_cols);
    assign w_interior = (r_emit_row != '0)
                        && (r_emit_row + CNT_ROW_W'(1) < CNT_ROW_W'(w_rows))
                        && (r_emit_col != '0) && !w_ec_wrap;
    assign w_last     = (r_emit_row + CNT_ROW_W'(1) >= CNT_ROW_W'(w_rows)) && w_ec_wrap;
    assign w_flt_start = (r_state == S_READ) && w_emit && w_interior;
    assign w_ec32     = 32'(r_emit_col);

    assign w_take     = r_out_valid && m_axis_tready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_window   <= '0;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_emit_row <= '0;
            r_emit_col <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_pix   <= w_drain ? '0 : s_axis_tdata;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_window[i*3+0] <= r_window[i*3+1];
                        r_window[i*3+1] <= r_window[i*3+2];
                    end
                    r_window[2] <= w_top;
                    r_window[5] <= w_mid;
                    r_window[8] <= r_pix;

                    if (w_emit && w_last) begin
                        r_in_row   <= '0;
                        r_in_col   <= '0;
                        r_emit_row <= '0;
                        r_emit_col <= '0;
                    end else begin
                        if (w_col_wrap) begin
                            r_in_col <= '0;
                            r_in_row <= r_in_row + CNT_ROW_W'(1);
                        end else begin
                            r_in_col <= r_in_col + AW'(1);
                        end
                        if (w_emit) begin
                            if (w_ec_wrap) begin
                                r_emit_col <= '0;
                                r_emit_row <= r_emit_row + CNT_ROW_W'(1);
                            end else begin
                                r_emit_col <= r_emit_col + AW'(1);
                            end
                        end
                    end

                    if (w_emit) begin
                        r_res_row <= r_emit_row[ROW_W-1:0];
                        r_res_col <= w_ec32[COL_W-1:0];
                        r_res_last <= w_last;
                        // A border pixel passes through as pixel * 16; the
                        // centre tap after the shift is the old right column.
                        r_res_value <= {1'b0, r_window[5], 4'b0000};
                        r_res_zero  <= 1'b0;
                        r_state <= w_interior ? S_CALC : S_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CALC: begin
                    if (w_sts.done) begin
                        r_res_value <= w_sts.value;
                        r_res_zero  <= w_sts.zero_kernel;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: the next item is taken while a result waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_tdata <= {(TDATA_W - VAL_W - COL_W - ROW_W)'(0),
                            r_res_value, r_res_col, r_res_row};
            r_out_tuser <= r_res_zero;
            r_out_tlast <= r_res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;
    assign m_axis_tlast  = r_out_tlast;

    ncv_linemem #(
        .DEPTH (MAX_COLS)
    ) u_linemem (
        .i_clk     (i_clk),
        .i_rd_en   (w_mem_rd),
        .i_rd_addr (r_in_col),
        .i_wr_en   (w_mem_wr),
        .i_wr_addr (r_in_col),
        .i_wr_data ({w_mid, r_pix}),
        .o_rd_data (w_rd_data)
    );

    ncv_filter u_filter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_flt_start),
        .i_window        (r_window),
        .i_kernel_top    (r_kernel_top),
        .i_kernel_middle (r_kernel_middle),
        .i_kernel_bottom (r_kernel_bottom),
        .o_sts           (w_sts)
    );

    `NCV_ASSERT_NEVER(a_mem_rw_overlap, i_clk, i_rst_n, w_mem_rd && w_mem_wr, "line store read and write overlap")
    `NCV_ASSERT(a_zero_kernel_value, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[34:22] == '0), "zero kernel result not zero")
    `NCV_ASSERT(a_frame_restart, i_clk, i_rst_n, ((r_state == S_READ) && w_emit && w_last) |=> ((r_in_row == '0) && (r_emit_row == '0) && (r_emit_col == '0)), "counters not cleared after frame end")
    `NCV_ASSERT(a_quotient_range, i_clk, i_rst_n, w_sts.done |-> ((w_sts.value <= 13'sd4080) && (w_sts.value >= -13'sd4080)), "quotient out of range")

endmodule

>>> tb/normalized_conv3x3_stream_tb.sv
// Self-checking testbench for the normalized 3x3 convolution stream.
`timescale 1ns / 1ps
module normalized_conv3x3_stream_tb;
    import ncv_pkg::*;

    localparam int unsigned LINE_COLS   = 1024;
    localparam longint      CYCLE_LIMIT = 3000000;
    localparam int          RANDOM_ITEMS = 1350;
    // A lone item with no result can still be in flight after the last result.
    localparam int          SETTLE_CYCLES = 40;

    // One output transaction as the block should present it.
    typedef struct {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    zero_kernel;
        logic                    frame_end;
    } conv_result_t;

    // One directed frame: sizes, kernel rows, pixel fill, and typed values where obvious.
    typedef struct {
        int unsigned cols;
        int unsigned rows;
        logic [23:0] ktop;
        logic [23:0] kmid;
        logic [23:0] kbot;
        int          fill;          // -1 picks random pixels
        int          border_value;  // -1 means take the predictor's value
        int          inner_value;   // -1 means take the predictor's value
        logic        inner_zero;
    } frame_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   s_axis_tuser = REQ_PIXEL;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    normalized_conv3x3_stream dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the registers and of the block's frame state.
    logic [10:0]  sh_cols = 11'd1024;
    logic [11:0]  sh_rows = 12'd1024;
    logic [23:0]  sh_kernel [3];
    logic [7:0]   line_mem [2*LINE_COLS];
    logic [7:0]   win [3][3];
    int unsigned  in_row, in_col, emit_row, emit_col;
    bit           last_interior;

    conv_result_t pending_results [$];
    int           error_count = 0;
    longint       cycle_count = 0;
    int           burst_left = 0;
    int           typed_border = -1;
    int           typed_inner = -1;
    logic         typed_zero = 1'b0;
    bit           holdoff_request = 0;

    function automatic int eff_width();
        if (sh_cols == 0) return 1;
        if (sh_cols > LINE_COLS) return LINE_COLS;
        return sh_cols;
    endfunction

    function automatic int eff_height();
        return (sh_rows == 0) ? 1 : sh_rows;
    endfunction

    // Normalized correlation of the current window with the shadow kernel.
    task automatic correlate(output int val, output logic zk);
        int acc;
        int ksum;
        int c;
        acc = 0;
        ksum = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                c = int'($signed(sh_kernel[i][8*j +: 8]));
                acc += int'(win[i][j]) * c;
                ksum += (c < 0) ? -c : c;
            end
        end
        if (ksum == 0) begin
            val = 0;
            zk = 1'b1;
        end else begin
            val = (acc * 16) / ksum;
            zk = 1'b0;
        end
    endtask

    // Advances the shadow state by one accepted input transaction.
    task automatic advance_frame(input logic rt, input logic [7:0] px,
                                 output bit emitted, output conv_result_t r);
        int unsigned cols;
        int unsigned rows;
        bit          drain;
        int unsigned li;
        longint      k;
        int          val;
        logic        zk;
        logic [7:0]  p;
        cols = eff_width();
        rows = eff_height();
        drain = (in_row >= rows);
        p = px;
        emitted = 0;
        r = '{default: '0};
        last_interior = 0;
        if (rt == REQ_FLUSH && !drain) return;
        if (drain) p = 8'd0;
        li = in_col % LINE_COLS;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = line_mem[li];
        win[1][2] = line_mem[LINE_COLS + li];
        win[2][2] = p;
        line_mem[li] = line_mem[LINE_COLS + li];
        line_mem[LINE_COLS + li] = p;
        k = longint'(in_row) * cols + in_col;
        in_col++;
        if (in_col >= cols) begin
            in_col = 0;
            in_row++;
        end
        if (k < longint'(cols) + 1) return;
        if (emit_row >= 1 && emit_row + 1 < rows && emit_col >= 1 && emit_col + 1 < cols) begin
            correlate(val, zk);
            last_interior = 1;
        end else begin
            val = int'(win[1][1]) * 16;
            zk = 1'b0;
        end
        emitted = 1;
        r.row = emit_row[ROW_W-1:0];
        r.col = emit_col[COL_W-1:0];
        r.value = val[VAL_W-1:0];
        r.zero_kernel = zk;
        r.frame_end = (emit_row + 1 >= rows) && (emit_col + 1 >= cols);
        if (r.frame_end) begin
            in_row = 0;
            in_col = 0;
            emit_row = 0;
            emit_col = 0;
        end else begin
            emit_col++;
            if (emit_col >= cols) begin
                emit_col = 0;
                emit_row++;
            end
        end
    endtask

    // Offers one input transaction, in bursts separated by random gaps, and
    // records what it should produce once the block has taken it.
    task automatic send_item(input logic rt, input logic [7:0] px, output bit frame_done);
        int           gap;
        bit           emitted;
        conv_result_t r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        s_axis_tuser <= rt;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_frame(rt, px, emitted, r);
        frame_done = emitted && r.frame_end;
        if (emitted) begin
            if (last_interior) begin
                if (typed_inner >= 0) begin
                    r.value = typed_inner[VAL_W-1:0];
                    r.zero_kernel = typed_zero;
                end
            end else if (typed_border >= 0) begin
                r.value = typed_border[VAL_W-1:0];
            end
            pending_results.push_back(r);
        end
    endtask

    // Lowers the stream valid and lets every outstanding result drain.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write followed by a read that must return the written value.
    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] val);
        logic [31:0] mask;
        case (idx)
            REG_FRAME_COLS: begin
                mask = 32'h7FF;
                sh_cols = val[10:0];
            end
            REG_FRAME_ROWS: begin
                mask = 32'hFFF;
                sh_rows = val[11:0];
            end
            REG_KERNEL_TOP: begin
                mask = 32'hFF_FFFF;
                sh_kernel[0] = val[23:0];
            end
            REG_KERNEL_MIDDLE: begin
                mask = 32'hFF_FFFF;
                sh_kernel[1] = val[23:0];
            end
            default: begin
                mask = 32'hFF_FFFF;
                sh_kernel[2] = val[23:0];
            end
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= val & mask;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if ((prdata & mask) !== (val & mask))
            $error("register %s: expected %0h, actual %0h", idx.name(), val & mask, prdata);
        if ((prdata & mask) !== (val & mask)) error_count++;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_frame(input int unsigned cols, input int unsigned rows,
                             input logic [23:0] kt, input logic [23:0] km,
                             input logic [23:0] kb);
        cfg_write(REG_FRAME_COLS, cols);
        cfg_write(REG_FRAME_ROWS, rows);
        cfg_write(REG_KERNEL_TOP, kt);
        cfg_write(REG_KERNEL_MIDDLE, km);
        cfg_write(REG_KERNEL_BOTTOM, kb);
    endtask

    // Streams one whole frame, with stray flushes mixed in and a drain tail
    // of flushes and surplus pixels, until the item that yields the frame end is taken.
    task automatic stream_frame(input int fill, input int noise_pct, inout int items);
        int unsigned total;
        logic [7:0]  px;
        bit          done;
        total = eff_width() * eff_height();
        done = 0;
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(REQ_FLUSH, 8'($urandom), done);
            case ($urandom_range(0, 9))
                0: px = 8'd0;
                1: px = 8'd255;
                default: px = 8'($urandom);
            endcase
            if (fill >= 0) px = fill[7:0];
            send_item(REQ_PIXEL, px, done);
            items++;
        end
        while (!done) begin
            if ($urandom_range(0, 3) == 0)
                send_item(REQ_PIXEL, 8'($urandom), done);
            else
                send_item(REQ_FLUSH, 8'($urandom), done);
            items++;
        end
    endtask

    // Checks every output transaction against the oldest pending result.
    always @(posedge i_clk) begin
        conv_result_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("output transaction with no result pending: tdata %0h", m_axis_tdata);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (m_axis_tdata[11:0] !== e.row) begin
                    $error("out_row: expected %0d, actual %0d", e.row, m_axis_tdata[11:0]);
                    error_count++;
                end
                if (m_axis_tdata[21:12] !== e.col) begin
                    $error("out_col: expected %0d, actual %0d", e.col, m_axis_tdata[21:12]);
                    error_count++;
                end
                if (m_axis_tdata[34:22] !== e.value) begin
                    $error("value: expected %0d, actual %0d", e.value,
                           $signed(m_axis_tdata[34:22]));
                    error_count++;
                end
                if (m_axis_tuser !== e.zero_kernel) begin
                    $error("zero_kernel: expected %0b, actual %0b", e.zero_kernel, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tlast !== e.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", e.frame_end, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Receiver: stall pattern in segments (free running, choppy, sparse),
    // plus one long hold-off on request so the block backs up.
    int rx_mode = 0;
    int rx_left = 0;
    int holdoff_left = 0;
    always @(posedge i_clk) begin
        if (holdoff_request) begin
            holdoff_request = 0;
            holdoff_left = 600;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(10, 200);
        end
        rx_left--;
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("normalized_conv3x3_stream_tb failed");
            $finish;
        end
    end

    // Directed frames: a single pixel, a flat white frame under the reset
    // kernel (interior cancels to zero), and an all-zero kernel.
    frame_row_t directed [3] = '{
        '{1, 1, 24'h0100FF, 24'h0200FE, 24'h0100FF, 255, 4080, -1, 1'b0},
        '{3, 3, 24'h0100FF, 24'h0200FE, 24'h0100FF, 255, 4080, 0, 1'b0},
        '{3, 3, 24'h000000, 24'h000000, 24'h000000, -1, -1, 0, 1'b1}
    };

    initial begin
        int          items;
        int          cols;
        int          rows;
        int          frames;
        int          phase;
        logic [23:0] krow [3];
        sh_kernel[0] = 24'h0100FF;
        sh_kernel[1] = 24'h0200FE;
        sh_kernel[2] = 24'h0100FF;
        foreach (win[i, j]) win[i][j] = 8'd0;
        foreach (line_mem[i]) line_mem[i] = 8'd0;
        in_row = 0;
        in_col = 0;
        emit_row = 0;
        emit_col = 0;
        items = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[d]) begin
            set_frame(directed[d].cols, directed[d].rows, directed[d].ktop,
                      directed[d].kmid, directed[d].kbot);
            typed_border = directed[d].border_value;
            typed_inner = directed[d].inner_value;
            typed_zero = directed[d].inner_zero;
            stream_frame(directed[d].fill, 20, items);
            wait_idle();
        end
        typed_border = -1;
        typed_inner = -1;

        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS || phase < 6) begin
            // The first few phases visit zero sizes and thin or flat frames.
            case (phase)
                0: begin cols = 0; rows = 0; end
                1: begin cols = 1; rows = 40; end
                2: begin cols = 40; rows = 1; end
                3: begin cols = 2; rows = 2; end
                4: begin cols = 64; rows = 3; end
                default: begin
                    cols = $urandom_range(1, 9);
                    rows = $urandom_range(1, 8);
                end
            endcase
            for (int i = 0; i < 3; i++) begin
                case ($urandom_range(0, 7))
                    0: krow[i] = 24'h000000;
                    1: krow[i] = 24'h808080;
                    2: krow[i] = 24'h7F7F7F;
                    3: krow[i] = 24'h7F0080;
                    default: krow[i] = 24'($urandom);
                endcase
            end
            set_frame(cols, rows, krow[0], krow[1], krow[2]);
            frames = (phase < 5) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                if (phase == 5 && f == 0) holdoff_request = 1;
                stream_frame(-1, 8, items);
                // Now and then the sender pauses until everything is out.
                if ($urandom_range(0, 3) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    burst_left = 0;
                    @(posedge i_clk);
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        if (error_count == 0) begin
            $display("normalized_conv3x3_stream_tb passed");
        end else begin
            $display("normalized_conv3x3_stream_tb failed");
        end
        $finish;
    end

endmodule
